FILE: rtl/core/cfr_pkg.sv
// Shared constants and types for the continued-fraction rationalizer.
`default_nettype none
package cfr_pkg;

  localparam int FRAC_BITS = 32;
  localparam int INT_BITS  = 31;
  localparam int VAL_W     = INT_BITS + FRAC_BITS;
  localparam int NUM_W     = 31;
  localparam int TOL_W     = 32;
  localparam int TL_W      = 4;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_TERMS = 16;

  // term digit: integer part of a reciprocal, up to 2^FRAC_BITS
  localparam int A_W   = FRAC_BITS + 1;
  // quotient of 2^(2*FRAC_BITS) by the fraction
  localparam int Q_W   = 2 * FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int N_W   = $clog2(MAX_TERMS);
  localparam int LIM_W = $clog2(MAX_TERMS + 1);

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE  = 1'b0,
    REG_TERM_LIMIT = 1'b1
  } cfr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CHK  = 4'b0100,
    ST_DIV  = 4'b1000
  } cfr_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/continued_fraction_rationalizer.sv
// Top level: continued-fraction expansion of a Q31.32 value into a fraction.
// One item at a time. Each term is a bit-serial multiply-add, a check step and
// a radix-2 reciprocal division; an item has 1 to 16 terms. busy is low again
// in the cycle out_valid is high.
// Synchronous active-low reset restores tolerance 4295 and term limit 11.
`default_nettype none
module continued_fraction_rationalizer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cfr_pkg::VAL_W-1:0]     in_value,
  output logic                               out_valid,
  output logic      [cfr_pkg::NUM_W-1:0]     out_numerator,
  output logic      [cfr_pkg::NUM_W-1:0]     out_denominator,
  output logic                               out_overflow,
  input  wire logic                          cfg_we,
  input  wire logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cfr_pkg::CFG_W-1:0]     cfg_wdata
);
  import cfr_pkg::*;

  cfr_state_t           state_r, state_nxt;
  logic [TOL_W-1:0]     tol_r;
  logic [TL_W-1:0]      tl_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [N_W-1:0]       n_r;
  logic [A_W-1:0]       a_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [NUM_W-1:0]     h0_r, h1_r, k0_r, k1_r;
  logic                 div_go_r;
  logic                 out_valid_r;
  logic [NUM_W-1:0]     out_num_r, out_den_r;
  logic                 out_ovf_r;

  logic                 accept;
  logic                 mac_clr;
  logic                 mac_step;
  logic [NUM_W-1:0]     h_res, k_res;
  logic                 h_fits, k_fits;
  logic                 div_done;
  logic [Q_W-1:0]       div_quo;
  logic [LIM_W-1:0]     lim_raw, limit;
  logic                 stop;

  assign accept   = start && (state_r == ST_IDLE);
  assign mac_step = (state_r == ST_MUL);
  assign mac_clr  = accept || div_done;

  cfr_mac u_mac_h (
    .clk   (clk),
    .clr   (mac_clr),
    .step  (mac_step),
    .a_bit (a_r[A_W-1]),
    .x     (h1_r),
    .y     (h0_r),
    .res   (h_res),
    .fits  (h_fits)
  );

  cfr_mac u_mac_k (
    .clk   (clk),
    .clr   (mac_clr),
    .step  (mac_step),
    .a_bit (a_r[A_W-1]),
    .x     (k1_r),
    .y     (k0_r),
    .res   (k_res),
    .fits  (k_fits)
  );

  cfr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go_r),
    .divisor (frac_r),
    .done    (div_done),
    .quo     (div_quo)
  );

  assign lim_raw = LIM_W'(tl_r) + 1'b1;
  assign limit   = (lim_raw > LIM_W'(MAX_TERMS)) ? LIM_W'(MAX_TERMS) : lim_raw;
  assign stop    = (LIM_W'(n_r) + 1'b1 >= limit) || (frac_r == '0) || (frac_r < tol_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == CNT_W'(A_W - 1)) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (!(h_fits && k_fits) || stop) ? ST_IDLE : ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tol_r       <= TOL_W'(4295);
      tl_r        <= TL_W'(11);
      cnt_r       <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_go_r    <= (state_r == ST_CHK) && (state_nxt == ST_DIV);
      out_valid_r <= (state_r == ST_CHK) && (state_nxt == ST_IDLE);
      if (state_r == ST_MUL && state_nxt == ST_MUL) cnt_r <= cnt_r + 1'b1;
      else cnt_r <= '0;
      if (cfg_we) begin
        unique case (cfr_reg_t'(cfg_index))
          REG_TOLERANCE:  tol_r <= cfg_wdata[TOL_W-1:0];
          REG_TERM_LIMIT: tl_r  <= cfg_wdata[TL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= A_W'(in_value[VAL_W-1:FRAC_BITS]);
      frac_r <= in_value[FRAC_BITS-1:0];
      n_r    <= '0;
      h1_r   <= NUM_W'(1);
      h0_r   <= '0;
      k1_r   <= '0;
      k0_r   <= NUM_W'(1);
    end else begin
      if (state_r == ST_MUL) a_r <= {a_r[A_W-2:0], 1'b0};
      if (state_r == ST_CHK) begin
        if (h_fits && k_fits) begin
          h0_r <= h1_r;
          h1_r <= h_res;
          k0_r <= k1_r;
          k1_r <= k_res;
          out_num_r <= h_res;
          out_den_r <= k_res;
          out_ovf_r <= 1'b0;
        end else begin
          // on overflow the previous convergent stands; none yet on the first term
          out_num_r <= (n_r == '0) ? NUM_MAX : h1_r;
          out_den_r <= (n_r == '0) ? NUM_W'(1) : k1_r;
          out_ovf_r <= 1'b1;
        end
      end
      if (state_r == ST_DIV && div_done) begin
        a_r    <= div_quo[Q_W-1:FRAC_BITS];
        frac_r <= div_quo[FRAC_BITS-1:0];
        n_r    <= n_r + 1'b1;
      end
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;
  assign out_overflow    = out_ovf_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after a start transfer");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_den_r != '0))
    else $error("zero denominator delivered");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (frac_r != '0))
    else $error("reciprocal of a zero fraction");

endmodule
`default_nettype wire

FILE: rtl/core/cfr_mac.sv
// Bit-serial multiply-add: res = a*x + y, with a fit flag.
`default_nettype none
module cfr_mac (
  input  wire logic                      clk,
  input  wire logic                      clr,
  input  wire logic                      step,
  input  wire logic                      a_bit,
  input  wire logic [cfr_pkg::NUM_W-1:0] x,
  input  wire logic [cfr_pkg::NUM_W-1:0] y,
  output logic      [cfr_pkg::NUM_W-1:0] res,
  output logic                           fits
);
  import cfr_pkg::*;

  logic [NUM_W-1:0] acc_r;
  logic             sticky_r;
  logic [NUM_W+1:0] acc_nxt;
  logic [NUM_W:0]   sum;

  // MSB-first: acc = 2*acc + a_bit*x; once past NUM_MAX the sticky flag stays set
  assign acc_nxt = {1'b0, acc_r, 1'b0} + {2'b00, (a_bit ? x : '0)};
  assign sum     = {1'b0, acc_r} + {1'b0, y};
  assign res     = sum[NUM_W-1:0];
  assign fits    = !sticky_r && !sum[NUM_W];

  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r    <= '0;
      sticky_r <= 1'b0;
    end else if (step) begin
      acc_r <= acc_nxt[NUM_W-1:0];
      if (acc_nxt[NUM_W+1:NUM_W] != 2'b00) sticky_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cfr_div.sv
// Restoring radix-2 divider: quotient of 2^(2*FRAC_BITS) by a nonzero fraction.
`default_nettype none
module cfr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [cfr_pkg::FRAC_BITS-1:0] divisor,
  output logic                               done,
  output logic      [cfr_pkg::Q_W-1:0]       quo
);
  import cfr_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [FRAC_BITS-1:0] rem_r;
  logic [Q_W-1:0]       q_r;
  logic [FRAC_BITS:0]   trial;
  logic                 ge;
  logic [FRAC_BITS:0]   diff;

  // dividend is a single one in its top bit, zeros below
  assign trial = {rem_r, (cnt_r == '0)};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[FRAC_BITS-1:0] : trial[FRAC_BITS-1:0];
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire
